// ----- rtl/least_squares_coordinate_descent_unit_defines.svh -----
// ----------------------------------------------------------------------------
// least squares coordinate descent unit: assertion macros
// shared concurrent check forms used by the rtl files
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_COORDINATE_DESCENT_UNIT_DEFINES_SVH
`define LEAST_SQUARES_COORDINATE_DESCENT_UNIT_DEFINES_SVH

// check that is switched off while reset is held
`define LSCD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lscd check failed");

// check that also holds while reset is held
`define LSCD_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lscd reset check failed");

`endif

// ----- rtl/lscd_pkg.sv -----
// ----------------------------------------------------------------------------
// lscd_pkg
// types, codes and saturating helpers of the coordinate descent unit
// ----------------------------------------------------------------------------
`default_nettype none

package lscd_pkg;

  localparam int unsigned SWEEP_LIMIT = 48;

  // input operations
  typedef enum logic [1:0] {
    OP_LOAD_FEATURE = 2'd0,
    OP_LOAD_LABEL   = 2'd1,
    OP_RUN          = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_POINT_COUNT     = 2'd0,
    REG_DIM_COUNT       = 2'd1,
    REG_ITERATION_COUNT = 2'd2
  } cfg_reg_e;

  // product shift back to q32.32
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_32 = 2'd2
  } shift_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_N_RD,
    S_N_MUL,
    S_N_W,
    S_DIM,
    S_NUM_RD,
    S_NUM_M1,
    S_NUM_W1,
    S_NUM_M2,
    S_NUM_W2,
    S_DIV_GO,
    S_DIV_W,
    S_UPD_RD,
    S_UPD_M,
    S_UPD_W,
    S_LOSS_RD,
    S_LOSS_M,
    S_LOSS_W,
    S_OUT_LOSS,
    S_OUT_W
  } state_e;

  typedef struct packed {
    logic   start;
    shift_e shift;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x[63] ? (64'd0 - 64'(x)) : 64'(x);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lscd_if.sv -----
// ----------------------------------------------------------------------------
// lscd channel interfaces
// input item, result and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface lscd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [9:0]  row_index;
  logic [3:0]  column_index;
  logic signed [31:0] value;
  modport source (output valid, operation, row_index, column_index, value, input ready);
  modport sink   (input valid, operation, row_index, column_index, value, output ready);
endinterface

interface lscd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  index;
  logic signed [63:0] result_value;
  logic        last;
  modport source (output valid, kind, index, result_value, last, input ready);
  modport sink   (input valid, kind, index, result_value, last, output ready);
endinterface

interface lscd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/lscd_mul.sv -----
// ----------------------------------------------------------------------------
// lscd_mul
// shared saturating multiplier: 64x64 magnitude product from four 32x32
// partial products, shifted back and saturated to 64 bits
// ----------------------------------------------------------------------------
`default_nettype none

module lscd_mul (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lscd_pkg::mul_ctl_t  ctl_i,
  input  wire logic signed [63:0]  x_i,
  input  wire logic signed [63:0]  y_i,
  output lscd_pkg::unit_sts_t      sts_o,
  output logic signed [63:0]       res_o
);

  logic [63:0]       a_q, b_q;
  logic              neg_q;
  lscd_pkg::shift_e  sh_q;
  logic [2:0]        cnt_q;
  logic              busy_q, done_q;
  logic [63:0]       pp_q;
  logic [127:0]      acc_q;
  logic signed [63:0] res_q;

  logic [31:0]  a_half, b_half;
  logic [127:0] pp_ext;
  logic [127:0] shifted;
  logic         over;
  logic [63:0]  r;
  logic signed [63:0] fin;

  // partial product operand select
  assign a_half = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  // alignment of the partial product taken last cycle
  always_comb begin
    unique case (cnt_q)
      3'd2, 3'd3: pp_ext = {32'd0, pp_q, 32'd0};
      3'd4:       pp_ext = {pp_q, 64'd0};
      default:    pp_ext = {64'd0, pp_q};
    endcase
  end

  // shift back, truncate toward zero, saturate
  always_comb begin
    unique case (sh_q)
      lscd_pkg::SH_16: shifted = acc_q >> 16;
      lscd_pkg::SH_32: shifted = acc_q >> 32;
      default:         shifted = acc_q;
    endcase
    over = shifted[127:64] != 64'd0;
    r    = shifted[63:0];
    if (neg_q) begin
      if (over || r[63]) begin
        fin = {1'b1, 63'd0};
      end else begin
        fin = -$signed(r);
      end
    end else begin
      if (over || r[63]) begin
        fin = {1'b0, {63{1'b1}}};
      end else begin
        fin = $signed(r);
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q   <= lscd_pkg::mag(x_i);
      b_q   <= lscd_pkg::mag(y_i);
      neg_q <= x_i[63] ^ y_i[63];
      sh_q  <= ctl_i.shift;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        pp_q <= a_half * b_half;
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
        acc_q <= acc_q + pp_ext;
      end
      if (cnt_q == 3'd5) begin
        res_q <= fin;
      end
    end
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/lscd_div.sv -----
// ----------------------------------------------------------------------------
// lscd_div
// bit-serial restoring divider: q32.32 over q32.32 to a saturated q16.16
// weight, rounded toward zero, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lscd_div #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [63:0]            num_i,
  input  wire logic signed [63:0]            den_i,
  output lscd_pkg::unit_sts_t                sts_o,
  output logic signed [VALUE_WIDTH-1:0]      quot_o
);

  localparam int unsigned QW = 80;
  localparam logic [QW-1:0] LIM = (QW'(1) << (VALUE_WIDTH - 1)) - QW'(1);

  logic [6:0]     cnt_q;
  logic           busy_q, done_q;
  logic [63:0]    rem_q, den_q;
  logic [QW-1:0]  dvd_q;
  logic           neg_q;
  logic signed [VALUE_WIDTH-1:0] quot_q;

  logic [64:0]    rem_sh, rem_sub;
  logic           ge;
  logic [QW-1:0]  qc;
  logic [QW-1:0]  q_fin;

  // one restoring step
  assign rem_sh  = {rem_q, dvd_q[QW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  // saturate to the weight range
  always_comb begin
    qc = (dvd_q > LIM + QW'(1)) ? LIM + QW'(1) : dvd_q;
    if (neg_q) begin
      q_fin = QW'(0) - qc;
    end else begin
      q_fin = (qc > LIM) ? LIM : qc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'(QW)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= 64'(den_i);
      dvd_q <= {lscd_pkg::mag(num_i), 16'd0};
      neg_q <= num_i[63];
    end else if (busy_q) begin
      if (cnt_q < 7'(QW)) begin
        rem_q <= ge ? rem_sub[63:0] : rem_sh[63:0];
        dvd_q <= {dvd_q[QW-2:0], ge};
      end else begin
        quot_q <= $signed(q_fin[VALUE_WIDTH-1:0]);
      end
    end
  end

  assign sts_o  = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- rtl/least_squares_coordinate_descent_unit.sv -----
// ----------------------------------------------------------------------------
// least squares coordinate descent unit
// loads a feature matrix and labels, then runs coordinate descent and
// reports the loss of every sweep and the final weights
// ----------------------------------------------------------------------------
// usage
//   in_i   : one word per item; operation 0 loads a feature at row/column,
//            1 loads a label at row, 2 starts a run.
//   cfg_i  : register writes (point, dimension and sweep counts), always
//            ready; write only while the unit is idle.
//   out_o  : one loss word per sweep, then one weight word per dimension,
//            the final one with last set.
//   units  : every product goes through one shared multiplier, and each
//            weight through an 80-step serial divider.
//   in_i is not ready while a run is in progress.
//   a stalled receiver holds the result register; the sequencer stops at
//   its next output word until the held word is taken.
//   reset returns the counts to one and the unit to idle; feature and
//   label stores keep no reset value and must be loaded before a run.
// ----------------------------------------------------------------------------
`default_nettype none
`include "least_squares_coordinate_descent_unit_defines.svh"

module least_squares_coordinate_descent_unit #(
  parameter int unsigned MAX_POINTS  = 1024,
  parameter int unsigned MAX_DIMS    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lscd_in_if.sink   in_i,
  lscd_out_if.source out_o,
  lscd_cfg_if.sink  cfg_i
);

  localparam int unsigned FDEPTH = MAX_POINTS * MAX_DIMS;
  localparam int unsigned FAW = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int unsigned PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned LW  = (VW < 32) ? VW : 32;

  // configuration registers
  logic [10:0] pc_q;
  logic [4:0]  dc_q;
  logic [5:0]  ic_q;

  // stores
  logic signed [VW-1:0] fe_mem [FDEPTH];
  logic signed [VW-1:0] lab_mem [MAX_POINTS];
  logic signed [63:0]   pred_mem [MAX_POINTS];
  logic signed [VW-1:0] w_q [MAX_DIMS];
  logic signed [63:0]   norm_q [MAX_DIMS];

  logic signed [VW-1:0] fe_rd_q, lab_rd_q;
  logic signed [63:0]   pred_rd_q;

  // sequencer registers
  lscd_pkg::state_e state_q, state_d;
  logic [DW-1:0]  i_q, i_d;
  logic [PW-1:0]  j_q, j_d;
  logic [5:0]     it_q, it_d;
  logic [CW-1:0]  n_q, n_d;
  logic [4:0]     m_q, m_d;
  logic [5:0]     iters_q, iters_d;
  logic signed [63:0]   acc_q, acc_d;
  logic signed [63:0]   tmp_q, tmp_d;
  logic signed [VW-1:0] wnew_q, wnew_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic        out_kind_q, out_kind_d;
  logic [5:0]  out_index_q, out_index_d;
  logic signed [63:0] out_value_q, out_value_d;
  logic        out_last_q, out_last_d;

  // controls
  logic in_ready;
  logic fe_we, lab_we, pred_we, norm_we, w_we, w_clr;
  logic signed [63:0] pred_wdata, norm_wdata;
  logic [FAW-1:0] fe_waddr, fe_raddr;
  logic signed [LW-1:0] load_low;
  logic signed [VW-1:0] load_val;

  lscd_pkg::mul_ctl_t  mul_ctl;
  lscd_pkg::unit_sts_t mul_sts, div_sts;
  logic signed [63:0]  mul_x, mul_y, mul_res;
  logic                div_start;
  logic signed [VW-1:0] div_quot;

  // derived values
  logic signed [63:0] fe64, lab16, pred64, wold64, delta64, diff64, acc_n;
  logic signed [VW:0] delta;
  logic jlast, ilast, itlast, out_free, row_ok, col_ok, run_go;

  assign load_low = in_i.value[LW-1:0];
  assign load_val = VW'(load_low);
  assign row_ok   = 32'(in_i.row_index) < MAX_POINTS;
  assign col_ok   = 32'(in_i.column_index) < MAX_DIMS;
  assign fe_waddr = FAW'(32'(in_i.row_index) * MAX_DIMS + 32'(in_i.column_index));
  assign fe_raddr = FAW'(32'(j_q) * MAX_DIMS + 32'(i_q));
  assign run_go   = in_i.valid && in_i.ready && (in_i.operation == lscd_pkg::OP_RUN);

  assign fe64    = 64'(fe_rd_q);
  assign lab16   = 64'(lab_rd_q) <<< 16;
  assign pred64  = pred_rd_q;
  assign wold64  = 64'(w_q[i_q]);
  assign delta   = (VW + 1)'(wnew_q) - (VW + 1)'(w_q[i_q]);
  assign delta64 = 64'(delta);
  assign diff64  = lscd_pkg::sat_sub(pred64, lab16);
  assign acc_n   = lscd_pkg::sat_add(acc_q, mul_res);

  assign jlast  = (32'(j_q) + 32'd1) == 32'(n_q);
  assign ilast  = (32'(i_q) + 32'd1) == 32'(m_q);
  assign itlast = (it_q + 6'd1) == iters_q;
  assign out_free = !out_valid_q || out_o.ready;

  // shared units
  lscd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .sts_o  (mul_sts),
    .res_o  (mul_res)
  );

  lscd_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (norm_q[i_q]),
    .sts_o   (div_sts),
    .quot_o  (div_quot)
  );

  // sequencer next state and controls
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    it_d        = it_q;
    n_d         = n_q;
    m_d         = m_q;
    iters_d     = iters_q;
    acc_d       = acc_q;
    tmp_d       = tmp_q;
    wnew_d      = wnew_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_index_d = out_index_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    in_ready    = 1'b0;
    fe_we       = 1'b0;
    lab_we      = 1'b0;
    pred_we     = 1'b0;
    pred_wdata  = '0;
    norm_we     = 1'b0;
    norm_wdata  = acc_n;
    w_we        = 1'b0;
    w_clr       = 1'b0;
    mul_ctl     = '{start: 1'b0, shift: lscd_pkg::SH_0};
    mul_x       = fe64;
    mul_y       = fe64;
    div_start   = 1'b0;

    unique case (state_q)
      lscd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          unique case (in_i.operation)
            lscd_pkg::OP_LOAD_FEATURE: fe_we  = row_ok && col_ok;
            lscd_pkg::OP_LOAD_LABEL:   lab_we = row_ok;
            lscd_pkg::OP_RUN: begin
              if (pc_q == 11'd0) begin
                n_d = CW'(1);
              end else if (32'(pc_q) > MAX_POINTS) begin
                n_d = CW'(MAX_POINTS);
              end else begin
                n_d = CW'(pc_q);
              end
              if (dc_q == 5'd0) begin
                m_d = 5'd1;
              end else if (32'(dc_q) > MAX_DIMS) begin
                m_d = 5'(MAX_DIMS);
              end else begin
                m_d = dc_q;
              end
              if (ic_q == 6'd0) begin
                iters_d = 6'd1;
              end else if (32'(ic_q) > lscd_pkg::SWEEP_LIMIT) begin
                iters_d = 6'(lscd_pkg::SWEEP_LIMIT);
              end else begin
                iters_d = ic_q;
              end
              i_d     = '0;
              j_d     = '0;
              it_d    = '0;
              acc_d   = '0;
              w_clr   = 1'b1;
              state_d = lscd_pkg::S_CLR;
            end
            default: ;
          endcase
        end
      end

      // clear predictions
      lscd_pkg::S_CLR: begin
        pred_we = 1'b1;
        if (jlast) begin
          j_d     = '0;
          state_d = lscd_pkg::S_N_RD;
        end else begin
          j_d = j_q + PW'(1);
        end
      end

      // squared column norms
      lscd_pkg::S_N_RD: state_d = lscd_pkg::S_N_MUL;
      lscd_pkg::S_N_MUL: begin
        mul_ctl = '{start: 1'b1, shift: lscd_pkg::SH_0};
        state_d = lscd_pkg::S_N_W;
      end
      lscd_pkg::S_N_W: begin
        if (mul_sts.done) begin
          state_d = lscd_pkg::S_N_RD;
          if (jlast) begin
            norm_we = 1'b1;
            acc_d   = '0;
            j_d     = '0;
            if (ilast) begin
              i_d     = '0;
              state_d = lscd_pkg::S_DIM;
            end else begin
              i_d = i_q + DW'(1);
            end
          end else begin
            acc_d = acc_n;
            j_d   = j_q + PW'(1);
          end
        end
      end

      // next dimension of a sweep
      lscd_pkg::S_DIM: begin
        acc_d = '0;
        j_d   = '0;
        if (norm_q[i_q] == 64'sd0) begin
          if (ilast) begin
            i_d     = '0;
            state_d = lscd_pkg::S_LOSS_RD;
          end else begin
            i_d = i_q + DW'(1);
          end
        end else begin
          state_d = lscd_pkg::S_NUM_RD;
        end
      end

      // numerator against the residual
      lscd_pkg::S_NUM_RD: state_d = lscd_pkg::S_NUM_M1;
      lscd_pkg::S_NUM_M1: begin
        mul_ctl = '{start: 1'b1, shift: lscd_pkg::SH_0};
        mul_y   = wold64;
        state_d = lscd_pkg::S_NUM_W1;
      end
      lscd_pkg::S_NUM_W1: begin
        if (mul_sts.done) begin
          tmp_d   = lscd_pkg::sat_sub(lab16, lscd_pkg::sat_sub(pred64, mul_res));
          state_d = lscd_pkg::S_NUM_M2;
        end
      end
      lscd_pkg::S_NUM_M2: begin
        mul_ctl = '{start: 1'b1, shift: lscd_pkg::SH_16};
        mul_y   = tmp_q;
        state_d = lscd_pkg::S_NUM_W2;
      end
      lscd_pkg::S_NUM_W2: begin
        if (mul_sts.done) begin
          acc_d = acc_n;
          if (jlast) begin
            j_d     = '0;
            state_d = lscd_pkg::S_DIV_GO;
          end else begin
            j_d     = j_q + PW'(1);
            state_d = lscd_pkg::S_NUM_RD;
          end
        end
      end

      // new weight
      lscd_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = lscd_pkg::S_DIV_W;
      end
      lscd_pkg::S_DIV_W: begin
        if (div_sts.done) begin
          wnew_d  = div_quot;
          state_d = lscd_pkg::S_UPD_RD;
        end
      end

      // prediction update
      lscd_pkg::S_UPD_RD: state_d = lscd_pkg::S_UPD_M;
      lscd_pkg::S_UPD_M: begin
        mul_ctl = '{start: 1'b1, shift: lscd_pkg::SH_0};
        mul_y   = delta64;
        state_d = lscd_pkg::S_UPD_W;
      end
      lscd_pkg::S_UPD_W: begin
        if (mul_sts.done) begin
          pred_we    = 1'b1;
          pred_wdata = lscd_pkg::sat_add(pred64, mul_res);
          if (jlast) begin
            w_we = 1'b1;
            j_d  = '0;
            if (ilast) begin
              i_d     = '0;
              acc_d   = '0;
              state_d = lscd_pkg::S_LOSS_RD;
            end else begin
              i_d     = i_q + DW'(1);
              state_d = lscd_pkg::S_DIM;
            end
          end else begin
            j_d     = j_q + PW'(1);
            state_d = lscd_pkg::S_UPD_RD;
          end
        end
      end

      // squared-error loss of the sweep
      lscd_pkg::S_LOSS_RD: state_d = lscd_pkg::S_LOSS_M;
      lscd_pkg::S_LOSS_M: begin
        mul_ctl = '{start: 1'b1, shift: lscd_pkg::SH_32};
        mul_x   = diff64;
        mul_y   = diff64;
        state_d = lscd_pkg::S_LOSS_W;
      end
      lscd_pkg::S_LOSS_W: begin
        if (mul_sts.done) begin
          acc_d = acc_n;
          if (jlast) begin
            j_d     = '0;
            state_d = lscd_pkg::S_OUT_LOSS;
          end else begin
            j_d     = j_q + PW'(1);
            state_d = lscd_pkg::S_LOSS_RD;
          end
        end
      end

      // loss word
      lscd_pkg::S_OUT_LOSS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = 1'b0;
          out_index_d = it_q + 6'd1;
          out_value_d = acc_q;
          out_last_d  = 1'b0;
          acc_d       = '0;
          i_d         = '0;
          if (itlast) begin
            state_d = lscd_pkg::S_OUT_W;
          end else begin
            it_d    = it_q + 6'd1;
            state_d = lscd_pkg::S_DIM;
          end
        end
      end

      // weight words
      lscd_pkg::S_OUT_W: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = 1'b1;
          out_index_d = 6'(i_q);
          out_value_d = 64'(w_q[i_q]) <<< 16;
          out_last_d  = ilast;
          if (ilast) begin
            state_d = lscd_pkg::S_IDLE;
          end else begin
            i_d = i_q + DW'(1);
          end
        end
      end

      default: state_d = lscd_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lscd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      pc_q        <= 11'd1;
      dc_q        <= 5'd1;
      ic_q        <= 6'd1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          lscd_pkg::REG_POINT_COUNT:     pc_q <= cfg_i.data[10:0];
          lscd_pkg::REG_DIM_COUNT:       dc_q <= cfg_i.data[4:0];
          lscd_pkg::REG_ITERATION_COUNT: ic_q <= cfg_i.data[5:0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    it_q        <= it_d;
    n_q         <= n_d;
    m_q         <= m_d;
    iters_q     <= iters_d;
    acc_q       <= acc_d;
    tmp_q       <= tmp_d;
    wnew_q      <= wnew_d;
    out_kind_q  <= out_kind_d;
    out_index_q <= out_index_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  // weights and column norms
  always_ff @(posedge clk_i) begin
    if (w_clr) begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        w_q[k] <= '0;
      end
    end else if (w_we) begin
      w_q[i_q] <= wnew_q;
    end
    if (norm_we) begin
      norm_q[i_q] <= norm_wdata;
    end
  end

  // feature store
  always_ff @(posedge clk_i) begin
    if (fe_we) begin
      fe_mem[fe_waddr] <= load_val;
    end
    fe_rd_q <= fe_mem[fe_raddr];
  end

  // label store
  always_ff @(posedge clk_i) begin
    if (lab_we) begin
      lab_mem[PW'(in_i.row_index)] <= load_val;
    end
    lab_rd_q <= lab_mem[j_q];
  end

  // prediction store
  always_ff @(posedge clk_i) begin
    if (pred_we) begin
      pred_mem[j_q] <= pred_wdata;
    end
    pred_rd_q <= pred_mem[j_q];
  end

  assign in_i.ready        = in_ready;
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.index       = out_index_q;
  assign out_o.result_value = out_value_q;
  assign out_o.last        = out_last_q;

  // checks
  `LSCD_ASSERT(a_mul_free, clk_i, rst_ni, mul_ctl.start |-> !mul_sts.busy)
  `LSCD_ASSERT(a_div_free, clk_i, rst_ni, div_start |-> !div_sts.busy)
  `LSCD_ASSERT(a_run_leaves_idle, clk_i, rst_ni, run_go |=> state_q != lscd_pkg::S_IDLE)
  `LSCD_ASSERT(a_last_is_weight, clk_i, rst_ni, (out_valid_q && out_last_q) |-> out_kind_q)
  `LSCD_ASSERT_RST(a_no_word_in_reset, clk_i, !rst_ni |=> !out_valid_q)

endmodule

`default_nettype wire
